/* rtl/core/dspb_pkg.sv */
// ----------------------------------------------------------------------------
// dspb_pkg
// Shared types and constants of the delayed synapse pulse blocker.
// ----------------------------------------------------------------------------
`default_nettype none

package dspb_pkg;

	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;
	localparam int DELAY_W      = 7;
	localparam int DIST_W       = 16;
	localparam int ELAPSED_W    = 16;
	localparam int STATE_CODE_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_DIST  = 1'b1;

	localparam logic [DELAY_W-1:0]   DELAY_RESET = 7'd8;
	localparam logic [DIST_W-1:0]    DIST_RESET  = 16'd100;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 16'hFFFF;

	localparam logic [STATE_CODE_W-1:0] CODE_IDLE   = 3'd0;
	localparam logic [STATE_CODE_W-1:0] CODE_LEAD   = 3'd1;
	localparam logic [STATE_CODE_W-1:0] CODE_BIDLE  = 3'd2;
	localparam logic [STATE_CODE_W-1:0] CODE_BPULSE = 3'd3;
	localparam logic [STATE_CODE_W-1:0] CODE_TRAIL  = 3'd4;

	typedef enum logic [4:0] {
		MODE_IDLE   = 5'b00001,
		MODE_LEAD   = 5'b00010,
		MODE_BIDLE  = 5'b00100,
		MODE_BPULSE = 5'b01000,
		MODE_TRAIL  = 5'b10000
	} mode_t;

	typedef struct packed {
		logic                    block_active;
		logic [STATE_CODE_W-1:0] fsm_state;
	} status_t;

	function automatic logic [STATE_CODE_W-1:0] mode_code(input mode_t m);
		logic [STATE_CODE_W-1:0] c;
		case (m)
			MODE_LEAD:   c = CODE_LEAD;
			MODE_BIDLE:  c = CODE_BIDLE;
			MODE_BPULSE: c = CODE_BPULSE;
			MODE_TRAIL:  c = CODE_TRAIL;
			default:     c = CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/dspb_cell.sv */
// ----------------------------------------------------------------------------
// dspb_cell
// One stage of the delay line: holds one potential and passes it on.
// ----------------------------------------------------------------------------
`default_nettype none

module dspb_cell #(
	parameter int W = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         shift_en,
	input  wire logic [W-1:0] d_in,
	output logic      [W-1:0] q_out
);

	logic [W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (shift_en) begin
			value_q <= d_in;
		end
	end

	assign q_out = value_q;

endmodule

`default_nettype wire

/* rtl/core/dspb_delay_line.sv */
// ----------------------------------------------------------------------------
// dspb_delay_line
// Row of delay cells that shifts once per item, with a tap chosen by the delay.
// ----------------------------------------------------------------------------
`default_nettype none

module dspb_delay_line #(
	parameter int MAX_DELAY = 64,
	parameter int W         = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        shift_en,
	input  wire logic [W-1:0]                add_potential,
	input  wire logic [dspb_pkg::DELAY_W-1:0] delay_ticks,
	output logic      [W-1:0]                delayed
);

	localparam int IDX_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;

	logic [W-1:0]     tap [MAX_DELAY];
	logic [31:0]      dsel;
	logic [IDX_W-1:0] tap_idx;

	genvar g;
	generate
		for (g = 0; g < MAX_DELAY; g++) begin : g_cell
			if (g == 0) begin : g_head
				dspb_cell #(.W(W)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.shift_en (shift_en),
					.d_in     (add_potential),
					.q_out    (tap[g])
				);
			end else begin : g_body
				dspb_cell #(.W(W)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.shift_en (shift_en),
					.d_in     (tap[g-1]),
					.q_out    (tap[g])
				);
			end
		end
	endgenerate

	// A delay of zero acts as one; a delay beyond the line acts as its length.
	always_comb begin
		dsel = 32'(delay_ticks);
		if (dsel == 32'd0) begin
			dsel = 32'd1;
		end else if (dsel > 32'(MAX_DELAY)) begin
			dsel = 32'(MAX_DELAY);
		end
		tap_idx = IDX_W'(dsel - 32'd1);
	end

	assign delayed = tap[tap_idx];

endmodule

`default_nettype wire

/* rtl/core/dspb_blocker.sv */
// ----------------------------------------------------------------------------
// dspb_blocker
// Saturating delayed add and the five-state pulse blocking machine.
// ----------------------------------------------------------------------------
`default_nettype none

module dspb_blocker #(
	parameter int W = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic [W-1:0]                 main_potential,
	input  wire logic [W-1:0]                 delayed,
	input  wire logic [dspb_pkg::DIST_W-1:0]  pulse_dist_ticks,
	output logic      [W-1:0]                 out_potential,
	output dspb_pkg::status_t                 status
);

	dspb_pkg::mode_t                  mode_q, mode_d;
	logic                             flag_q, flag_d;
	logic [dspb_pkg::ELAPSED_W-1:0]   elapsed_q, elapsed_d, elapsed_inc;
	logic [W:0]                       sum;
	logic [W-1:0]                     sat;
	logic                             sig;
	logic                             in_dist;

	always_comb begin
		sum = {main_potential[W-1], main_potential} + {delayed[W-1], delayed};
		if (sum[W] != sum[W-1]) begin
			sat = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			sat = sum[W-1:0];
		end
		sig = !sat[W-1] && (|sat);
		elapsed_inc = (elapsed_q != dspb_pkg::ELAPSED_MAX) ? elapsed_q + 1'b1 : elapsed_q;
		in_dist = elapsed_inc < pulse_dist_ticks;
	end

	always_comb begin
		mode_d        = mode_q;
		flag_d        = flag_q;
		elapsed_d     = elapsed_inc;
		out_potential = sat;
		case (mode_q)
			dspb_pkg::MODE_LEAD: begin
				if (!in_dist) begin
					mode_d = dspb_pkg::MODE_IDLE;
				end else if (!sig) begin
					flag_d = 1'b1;
					mode_d = dspb_pkg::MODE_BIDLE;
				end
			end
			dspb_pkg::MODE_BIDLE: begin
				if (sig) begin
					out_potential = '0;
					if (in_dist) begin
						mode_d = dspb_pkg::MODE_BPULSE;
					end else begin
						elapsed_d = '0;
						mode_d    = dspb_pkg::MODE_LEAD;
					end
				end else if (!in_dist) begin
					flag_d = 1'b0;
					mode_d = dspb_pkg::MODE_IDLE;
				end
			end
			dspb_pkg::MODE_BPULSE: begin
				if (sig) begin
					out_potential = '0;
					if (!in_dist) begin
						mode_d = dspb_pkg::MODE_TRAIL;
					end
				end else if (in_dist) begin
					mode_d = dspb_pkg::MODE_BIDLE;
				end else begin
					flag_d = 1'b0;
					mode_d = dspb_pkg::MODE_IDLE;
				end
			end
			dspb_pkg::MODE_TRAIL: begin
				if (sig) begin
					out_potential = '0;
				end else begin
					flag_d = 1'b0;
					mode_d = dspb_pkg::MODE_IDLE;
				end
			end
			default: begin
				mode_d = dspb_pkg::MODE_IDLE;
				if (sig) begin
					elapsed_d = '0;
					mode_d    = dspb_pkg::MODE_LEAD;
				end
			end
		endcase
		status.block_active = flag_d;
		status.fsm_state    = dspb_pkg::mode_code(mode_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= dspb_pkg::MODE_IDLE;
			flag_q    <= 1'b0;
			elapsed_q <= '0;
		end else if (step) begin
			mode_q    <= mode_d;
			flag_q    <= flag_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/dspb_out_skid.sv */
// ----------------------------------------------------------------------------
// dspb_out_skid
// Output register with a skid stage so the input side never waits on a
// combinational ready from the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module dspb_out_skid #(
	parameter int W = 24
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [W-1:0] in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic      [W-1:0] out_data
);

	logic         out_valid_q;
	logic         skid_valid_q;
	logic [W-1:0] out_data_q;
	logic [W-1:0] skid_data_q;
	logic         in_accept;

	assign in_ready  = !skid_valid_q;
	assign in_accept = in_valid && !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && out_ready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!in_accept) begin
				out_valid_q <= 1'b0;
			end
		end else if (!out_valid_q) begin
			if (in_accept) begin
				out_valid_q <= 1'b1;
			end
		end else if (in_accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out_ready) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (in_accept) begin
				out_data_q <= in_data;
			end
		end else if (!out_valid_q) begin
			if (in_accept) begin
				out_data_q <= in_data;
			end
		end else if (in_accept) begin
			skid_data_q <= in_data;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/delayed_synapse_pulse_blocker.sv */
// ----------------------------------------------------------------------------
// delayed_synapse_pulse_blocker
// Delayed additive synapse with saturation and a pulse blocking state machine.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tdata: main_potential, add_potential
// m_axis    out        tdata: out_potential, block_active, fsm_state
// cfg       in         cfg_we, cfg_index, cfg_data (0 delay_ticks, 1 pulse_dist_ticks)
//
// One item per cycle while s_axis_tready is high; each item's result is registered in the output buffer.
// The delay line is a row of MAX_DELAY cells that shifts once per item.
// Reset clears the delay line and the state machine at once and loads the config registers with their reset values.
// A two-entry output buffer lets input items flow while a result waits;
// s_axis_tready falls only when both entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

module delayed_synapse_pulse_blocker #(
	parameter int MAX_DELAY = 64,
	parameter int POT_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// main_potential, add_potential
	input  wire logic [((2*POT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// out_potential, block_active, fsm_state
	output logic [((POT_WIDTH+4+7)/8)*8-1:0]     m_axis_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [dspb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dspb_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int OUT_W = ((POT_WIDTH+4+7)/8)*8;

	logic [dspb_pkg::DELAY_W-1:0] delay_ticks_q;
	logic [dspb_pkg::DIST_W-1:0]  pulse_dist_q;
	logic                         in_accept;
	logic [POT_WIDTH-1:0]         main_potential;
	logic [POT_WIDTH-1:0]         add_potential;
	logic [POT_WIDTH-1:0]         delayed;
	logic [POT_WIDTH-1:0]         out_potential;
	dspb_pkg::status_t            status;
	logic [OUT_W-1:0]             result;

	assign main_potential = s_axis_tdata[POT_WIDTH-1:0];
	assign add_potential  = s_axis_tdata[2*POT_WIDTH-1:POT_WIDTH];
	assign in_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q <= dspb_pkg::DELAY_RESET;
			pulse_dist_q  <= dspb_pkg::DIST_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dspb_pkg::CFG_DELAY_TICKS: delay_ticks_q <= cfg_data[dspb_pkg::DELAY_W-1:0];
				dspb_pkg::CFG_PULSE_DIST:  pulse_dist_q  <= cfg_data[dspb_pkg::DIST_W-1:0];
				default: ;
			endcase
		end
	end

	dspb_delay_line #(
		.MAX_DELAY (MAX_DELAY),
		.W         (POT_WIDTH)
	) u_delay_line (
		.clk           (clk),
		.arst_n        (arst_n),
		.shift_en      (in_accept),
		.add_potential (add_potential),
		.delay_ticks   (delay_ticks_q),
		.delayed       (delayed)
	);

	dspb_blocker #(
		.W (POT_WIDTH)
	) u_blocker (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (in_accept),
		.main_potential   (main_potential),
		.delayed          (delayed),
		.pulse_dist_ticks (pulse_dist_q),
		.out_potential    (out_potential),
		.status           (status)
	);

	assign result = OUT_W'({status.fsm_state, status.block_active, out_potential});

	dspb_out_skid #(
		.W (OUT_W)
	) u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (result),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the delayed synapse pulse blocker.
// A scoreboard class keeps its own copy of the delay line, the window count and
// the blocking state machine, and predicts one result for every accepted input
// item. Results are compared in order. The stimulus starts with a short
// directed run at reset settings. Random pulse trains then run under several
// register settings and handshake pressures, and a long window run keeps
// pulses blocked for its whole length.
// ----------------------------------------------------------------------------

import dspb_pkg::*;

class blocker_scoreboard;
	typedef struct {
		logic [15:0]             potential;
		logic                    blocked;
		logic [STATE_CODE_W-1:0] state;
	} tick_result_t;

	logic signed [15:0]      line_mem [64];
	logic [5:0]              wr_ptr;
	logic [STATE_CODE_W-1:0] state_code;
	logic [ELAPSED_W-1:0]    since_lead;
	logic                    flag;
	logic [DELAY_W-1:0]      delay_reg;
	logic [DIST_W-1:0]       dist_reg;
	tick_result_t            awaited [$];
	int                      fails;

	function new();
		foreach (line_mem[i]) line_mem[i] = '0;
		wr_ptr     = '0;
		state_code = CODE_IDLE;
		since_lead = '0;
		flag       = 1'b0;
		delay_reg  = DELAY_RESET;
		dist_reg   = DIST_RESET;
		fails      = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		if (idx == CFG_DELAY_TICKS) begin
			delay_reg = data[DELAY_W-1:0];
		end else begin
			dist_reg = data[DIST_W-1:0];
		end
	endfunction

	// Input item: main potential in bits 15:0, add potential in bits 31:16.
	function void note_input(logic [31:0] item);
		logic signed [15:0] main_pot;
		logic signed [15:0] add_pot;
		logic signed [15:0] delayed;
		int                 d;
		int                 rd;
		int                 sum;
		logic               sig;
		logic               in_win;
		tick_result_t       r;
		main_pot = item[15:0];
		add_pot  = item[31:16];
		d = int'(delay_reg);
		if (d < 1) d = 1;
		if (d > 64) d = 64;
		rd = (int'(wr_ptr) + 64 - d) % 64;
		delayed = line_mem[rd];
		line_mem[wr_ptr] = add_pot;
		wr_ptr = wr_ptr + 6'd1;
		sum = int'(main_pot) + int'(delayed);
		if (sum > 32767) sum = 32767;
		else if (sum < -32768) sum = -32768;
		sig = (sum > 0);
		if (since_lead != ELAPSED_MAX) since_lead = since_lead + 1'b1;
		in_win = (since_lead < dist_reg);
		case (state_code)
			CODE_LEAD: begin
				if (!in_win) begin
					state_code = CODE_IDLE;
				end else if (!sig) begin
					flag       = 1'b1;
					state_code = CODE_BIDLE;
				end
			end
			CODE_BIDLE: begin
				if (sig) begin
					sum = 0;
					if (in_win) begin
						state_code = CODE_BPULSE;
					end else begin
						since_lead = '0;
						state_code = CODE_LEAD;
					end
				end else if (!in_win) begin
					flag       = 1'b0;
					state_code = CODE_IDLE;
				end
			end
			CODE_BPULSE: begin
				if (sig) begin
					sum = 0;
					if (!in_win) state_code = CODE_TRAIL;
				end else if (in_win) begin
					state_code = CODE_BIDLE;
				end else begin
					flag       = 1'b0;
					state_code = CODE_IDLE;
				end
			end
			CODE_TRAIL: begin
				if (sig) begin
					sum = 0;
				end else begin
					flag       = 1'b0;
					state_code = CODE_IDLE;
				end
			end
			default: begin
				state_code = CODE_IDLE;
				if (sig) begin
					since_lead = '0;
					state_code = CODE_LEAD;
				end
			end
		endcase
		r.potential = sum[15:0];
		r.blocked   = flag;
		r.state     = state_code;
		awaited.insert(awaited.size(), r);
	endfunction

	// Output item: potential in bits 15:0, block flag in bit 16, state in bits 19:17.
	function void check_output(logic [23:0] word);
		tick_result_t want;
		if (awaited.size() == 0) begin
			fails++;
			if (fails <= 10) $display("output item %h arrived with nothing expected", word);
			return;
		end
		want = awaited.pop_front();
		if (word[15:0] !== want.potential || word[16] !== want.blocked ||
				word[19:17] !== want.state) begin
			fails++;
			if (fails <= 10) begin
				$display("mismatch: expected potential %0d block %0b state %0d",
					$signed(want.potential), want.blocked, want.state);
				$display("          actual   potential %0d block %0b state %0d",
					$signed(word[15:0]), word[16], word[19:17]);
			end
		end
	endfunction

	function int pending();
		return awaited.size();
	endfunction
endclass

module tb;
	localparam int STALL_LIMIT = 2000;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  s_axis_tvalid  = 1'b0;
	logic                  s_axis_tready;
	logic [31:0]           s_axis_tdata   = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready  = 1'b0;
	logic [23:0]           m_axis_tdata;
	logic                  cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index      = CFG_DELAY_TICKS;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int quiet_cycles   = 0;
	blocker_scoreboard sb;

	delayed_synapse_pulse_blocker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Called and returning at a falling edge.
	task automatic send_item(input logic [15:0] main_pot, input logic [15:0] add_pot);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {add_pot, main_pot};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] delay_data,
			input logic [CFG_DATA_W-1:0] dist_data);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DELAY_TICKS;
		cfg_data  <= delay_data;
		sb.write_reg(CFG_DELAY_TICKS, delay_data);
		@(negedge clk);
		cfg_index <= CFG_PULSE_DIST;
		cfg_data  <= dist_data;
		sb.write_reg(CFG_PULSE_DIST, dist_data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Alternating runs of positive and non-positive sums, driven either by the
	// main potential or through the delay line, mixed with raw noise items.
	task automatic pulse_trains(input int count);
		int          left;
		int          run_len;
		int          cap;
		int          kind;
		int          v;
		bit          positive;
		logic [15:0] m;
		logic [15:0] a;
		positive = 1'($urandom_range(1));
		left = count;
		while (left > 0) begin
			kind = $urandom_range(99);
			cap = (sb.dist_reg > 150) ? 150 : int'(sb.dist_reg) + 3;
			run_len = (kind < 80) ? $urandom_range(cap, 1) : $urandom_range(4, 1);
			if (run_len > left) run_len = left;
			repeat (run_len) begin
				if (kind < 55) begin
					if (positive) v = $urandom_range(32767, 256);
					else v = -int'($urandom_range(32768, 256));
					m = v[15:0];
					v = int'($urandom_range(510)) - 255;
					a = v[15:0];
				end else if (kind < 80) begin
					m = '0;
					if (positive) v = $urandom_range(32767, 1);
					else v = -int'($urandom_range(32768, 0));
					a = v[15:0];
				end else begin
					m = 16'($urandom);
					a = 16'($urandom);
				end
				send_item(m, a);
			end
			left -= run_len;
			positive = !positive;
		end
	endtask

	logic [15:0] dir_main [19] = '{16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
		16'h8000, 16'h0100, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h8001,
		16'h0000, 16'h0000, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h0001};
	logic [15:0] dir_add [19] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
		16'h0001, 16'hFFFF, 16'h0000, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001};
	logic [15:0] delay_set [8] = '{16'd1, 16'd0, 16'd64, 16'd127, 16'd2, 16'h0F83,
		16'd65, 16'd63};
	logic [15:0] dist_set [8] = '{16'd0, 16'd1, 16'd2, 16'd5, 16'd10, 16'd30, 16'd100,
		16'd65535};
	int send_pct_set [4] = '{0, 67, 0, 29};
	int recv_pct_set [4] = '{0, 0, 67, 29};

	initial begin
		sb = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < 19; i++) send_item(dir_main[i], dir_add[i]);
		drain();

		for (int p = 0; p < 12; p++) begin
			if (p < 8) begin
				set_config(delay_set[p], dist_set[p]);
			end else begin
				set_config(16'($urandom_range(127)), 16'($urandom_range(40)));
			end
			send_idle_pct  = send_pct_set[p % 4];
			recv_stall_pct = recv_pct_set[p % 4];
			pulse_trains(125);
			drain();
		end

		// Long window: pulses stay blocked for the whole run.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_config(16'd1, 16'd0);
		send_item(16'hFF00, 16'h0000);
		send_item(16'hFF00, 16'h0000);
		drain();
		set_config(16'd1, 16'd65535);
		send_item(16'h0100, 16'h0000);
		send_item(16'hFF00, 16'h0000);
		repeat (40) send_item(16'h0100, 16'h0000);
		send_item(16'hFF00, 16'h0000);
		repeat (4) send_item(16'h0100, 16'h0000);
		drain();
		repeat (10) @(negedge clk);

		if (sb.fails == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
